@@ rtl/eki_pkg.sv @@
package eki_pkg;

    localparam int Q_W    = 24;
    localparam int E_W    = 18;
    localparam int PROD_W = 51;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic signed [E_W-1:0] ease_t;

    // Easing curve codes
    localparam logic [3:0] EASE_COS          = 4'd0;
    localparam logic [3:0] EASE_QUINTIC      = 4'd1;
    localparam logic [3:0] EASE_SQUARE       = 4'd2;
    localparam logic [3:0] EASE_SQ_QUINTIC   = 4'd3;
    localparam logic [3:0] EASE_SINE         = 4'd4;
    localparam logic [3:0] EASE_SMOOTH       = 4'd5;
    localparam logic [3:0] EASE_PRODUCT      = 4'd6;
    localparam logic [3:0] EASE_CATMULL      = 4'd7;
    localparam logic [3:0] EASE_QUART_SMOOTH = 4'd8;
    localparam logic [3:0] EASE_QUAD_OUT     = 4'd9;
    localparam logic [3:0] EASE_CONST        = 4'd10;

    localparam q_t Q_ONE     = 24'sd65536;
    localparam q_t Q_THREE   = 24'sd196608;
    localparam q_t Q_TEN     = 24'sd655360;
    localparam q_t Q_FIFTEEN = 24'sd983040;
    localparam q_t Q_SIX_INT = 24'sd6;
    localparam q_t Q_NINE_INT = 24'sd9;
    localparam q_t Q_EASE_MAX = 24'sd131071;
    localparam q_t Q_EASE_MIN = -24'sd131072;

    // ceil(2^19 / 3): exact floor division by three for values below 2^19
    localparam logic [17:0] THIRD_RECIP = 18'd174763;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [31:0]        anim_time;
        logic [31:0]        seg_start_time;
        logic [31:0]        seg_end_time;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } eki_req_t;

    typedef struct packed {
        logic               in_segment;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } eki_res_t;

    typedef struct packed {
        logic               inseg;
        logic               zero;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [32:0] diff_x;
        logic signed [32:0] diff_y;
        logic signed [32:0] diff_z;
    } eki_carry_t;

    // Q16 product, round to nearest with ties upward
    function automatic q_t qmul(q_t a, q_t b);
        logic signed [2*Q_W-1:0] p;
        p = a * b;
        p = p + 48'sd32768;
        return q_t'(p >>> 16);
    endfunction

    function automatic ease_t sat_ease(q_t v);
        ease_t r;
        if (v > Q_EASE_MAX)
            r = ease_t'(Q_EASE_MAX);
        else if (v < Q_EASE_MIN)
            r = ease_t'(Q_EASE_MIN);
        else
            r = ease_t'(v);
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] lerp_fin(logic signed [31:0] s,
                                                    logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] ps;
        logic signed [35:0]       sum;
        ps  = (p + 51'sd32768) >>> 16;
        sum = 36'(s) + 36'(ps);
        return sat32(sum);
    endfunction

    // Quarter-wave sine entry k in Q16, from a Q30 Taylor series
    function automatic logic [16:0] sin_entry(int unsigned k, int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] res;
        x    = (HALF_PI_Q30 * 64'(k)) >> tb;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        res = (sum + 64'd8192) >> 14;
        return res[16:0];
    endfunction

endpackage

@@ rtl/eased_keyframe_interpolator_unit.sv @@
// Eased keyframe interpolator. Each request carries an animation time and one
// keyframe segment; once the request has passed through the pipeline, done pulses
// for one cycle with the result: in_segment and the eased, saturated position
// (all zero when the time is outside the segment). The unit takes one request
// every clock and never stalls, so busy stays low; the receiver must take each
// result in the cycle it appears. Throughput is one request per cycle; the
// 17-stage restoring divider that forms the phase t is followed by five easing
// stages and two interpolation stages. ease_mode is written through the cfg
// channel; cfg_ready stays low while any request is in flight or being
// offered, so a new curve never mixes into older requests.
module eased_keyframe_interpolator_unit
    import eki_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 8
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  eki_req_t request,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [3:0] cfg_data,
    output logic     done,
    output eki_res_t result
);

    localparam int DIV_N    = 17;
    localparam int CARRY_N  = 24;
    localparam int VALID_N  = 25;
    localparam int LATENCY  = 25;
    localparam int FRAC_W   = 16 - TRIG_TABLE_BITS;
    localparam int IDX_W    = TRIG_TABLE_BITS + 1;
    localparam int SIN_N    = (1 << TRIG_TABLE_BITS) + 1;
    localparam int SP_W     = 19 + FRAC_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(1 << TRIG_TABLE_BITS);
    localparam logic signed [SP_W-1:0] SP_HALF = SP_W'(1 << (FRAC_W - 1));

    // ---------------------------------------------------------------
    // Control: the pipeline never stalls.
    // ---------------------------------------------------------------
    logic       valid_reg [0:VALID_N-1];
    logic [3:0] ease_mode_reg;
    logic       pipe_idle;

    // Hold off mode writes until every stage is empty.
    always_comb
    begin
        pipe_idle = 1'b1;
        for (int i = 0; i < VALID_N; i++)
            if (valid_reg[i])
                pipe_idle = 1'b0;
    end

    assign busy      = 1'b0;
    assign cfg_ready = pipe_idle && !start;
    assign done      = valid_reg[VALID_N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ease_mode_reg <= EASE_QUINTIC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ease_mode_reg <= cfg_data;
        end
    end

    // Advance a valid bit alongside every request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VALID_N; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int i = 1; i < VALID_N; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Capture: segment test, divider operands, position deltas.
    // ---------------------------------------------------------------
    eki_carry_t  carry_reg [0:CARRY_N-1];
    eki_carry_t  carry_next;
    logic [31:0] div_rem_reg [0:DIV_N-1];
    logic [31:0] div_den_reg [0:DIV_N-1];
    logic [16:0] div_quo_reg [1:DIV_N];

    always_comb
    begin
        carry_next.inseg   = (request.anim_time >= request.seg_start_time) &&
                             (request.anim_time <= request.seg_end_time);
        carry_next.zero    = request.seg_start_time == request.seg_end_time;
        carry_next.start_x = request.start_x;
        carry_next.start_y = request.start_y;
        carry_next.start_z = request.start_z;
        carry_next.diff_x  = {request.end_x[31], request.end_x}
                           - {request.start_x[31], request.start_x};
        carry_next.diff_y  = {request.end_y[31], request.end_y}
                           - {request.start_y[31], request.start_y};
        carry_next.diff_z  = {request.end_z[31], request.end_z}
                           - {request.start_z[31], request.start_z};
    end

    always_ff @(posedge clk)
    begin
        carry_reg[0]   <= carry_next;
        div_rem_reg[0] <= request.anim_time - request.seg_start_time;
        div_den_reg[0] <= request.seg_end_time - request.seg_start_time;
        for (int i = 1; i < CARRY_N; i++)
            carry_reg[i] <= carry_reg[i-1];
    end

    // ---------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, MSB (weight 2^16)
    // first. The remainder never exceeds the divisor inside a segment.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        logic [32:0] rem_shift;
        logic [32:0] rem_next;
        logic        bit_next;

        always_comb
        begin
            if (j == 0)
                rem_shift = {1'b0, div_rem_reg[j]};
            else
                rem_shift = {div_rem_reg[j], 1'b0};
            bit_next = rem_shift >= {1'b0, div_den_reg[j]};
            rem_next = bit_next ? rem_shift - {1'b0, div_den_reg[j]} : rem_shift;
        end

        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                div_quo_reg[1] <= {16'b0, bit_next};
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                div_quo_reg[j+1] <= {div_quo_reg[j][15:0], bit_next};
            end
        end

        if (j < DIV_N - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                div_rem_reg[j+1] <= rem_next[31:0];
                div_den_reg[j+1] <= div_den_reg[j];
            end
        end
    end

    // ---------------------------------------------------------------
    // Quarter-wave sine table, built at elaboration.
    // ---------------------------------------------------------------
    logic [16:0] sin_tab [SIN_N];

    for (genvar k = 0; k < SIN_N; k++)
    begin : g_sin
        localparam logic [16:0] ENTRY = sin_entry(k, TRIG_TABLE_BITS);
        assign sin_tab[k] = ENTRY;
    end

    // ---------------------------------------------------------------
    // E0: form t, fold the cosine phase, look up two sine entries.
    // ---------------------------------------------------------------
    logic [16:0]              t_next;
    logic [17:0]              two_t;
    logic                     hi_next;
    logic [16:0]              phase;
    logic [17:0]              phase_wide;
    logic [IDX_W-1:0]         idx0;
    logic [IDX_W-1:0]         idx1;
    logic [16:0]              e0_t_reg;
    logic                     e0_hi_reg;
    logic [16:0]              e0_s0_reg;
    logic signed [17:0]       e0_ds_reg;
    logic [FRAC_W-1:0]        e0_frac_reg;

    always_comb
    begin
        t_next     = carry_reg[DIV_N].zero ? 17'd65536 : div_quo_reg[DIV_N];
        two_t      = {t_next, 1'b0};
        hi_next    = t_next > 17'd32768;
        phase_wide = hi_next ? two_t - 18'd65536 : 18'd65536 - two_t;
        if (ease_mode_reg == EASE_COS)
            phase = phase_wide[16:0];
        else
            phase = t_next;
        idx0 = phase[16 -: IDX_W];
        idx1 = (idx0 == IDX_LAST) ? idx0 : idx0 + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        e0_t_reg    <= t_next;
        e0_hi_reg   <= hi_next;
        e0_s0_reg   <= sin_tab[idx0];
        e0_ds_reg   <= signed'({1'b0, sin_tab[idx1]}) - signed'({1'b0, sin_tab[idx0]});
        e0_frac_reg <= phase[FRAC_W-1:0];
    end

    // ---------------------------------------------------------------
    // E1: sine interpolation, t^2, (1-t)^2, quintic inner term.
    // ---------------------------------------------------------------
    q_t                    e1_tq;
    logic signed [SP_W-1:0] e1_sp;
    q_t e1_t_reg, e1_tt_reg, e1_uu_reg, e1_inner_reg, e1_sin_reg;
    logic e1_hi_reg;

    always_comb
    begin
        e1_tq = q_t'({7'b0, e0_t_reg});
        e1_sp = e0_ds_reg * signed'({1'b0, e0_frac_reg});
        e1_sp = e1_sp + SP_HALF;
    end

    always_ff @(posedge clk)
    begin
        e1_t_reg     <= e1_tq;
        e1_hi_reg    <= e0_hi_reg;
        e1_sin_reg   <= q_t'({7'b0, e0_s0_reg}) + q_t'(e1_sp >>> FRAC_W);
        e1_tt_reg    <= qmul(e1_tq, e1_tq);
        e1_uu_reg    <= qmul(Q_ONE - e1_tq, Q_ONE - e1_tq);
        e1_inner_reg <= qmul(e1_tq, Q_SIX_INT * e1_tq - Q_FIFTEEN) + Q_TEN;
    end

    // ---------------------------------------------------------------
    // E2: cosine blend weight (divide by three), second product level.
    // ---------------------------------------------------------------
    q_t          e2_c;
    q_t          e2_cp1;
    logic [35:0] e2_third;
    q_t          e2_opa;
    q_t          e2_opb;
    q_t e2_t_reg, e2_tt_reg, e2_uu_reg, e2_sin_reg, e2_inner_reg;
    q_t e2_r2a_reg, e2_r2b_reg, e2_a_reg;

    always_comb
    begin
        e2_c     = e1_hi_reg ? Q_ONE + e1_sin_reg : Q_ONE - e1_sin_reg;
        e2_cp1   = e2_c + q_t'(1);
        e2_third = 36'(e2_cp1[17:0]) * 36'(THIRD_RECIP);
        case (ease_mode_reg) inside
            EASE_SMOOTH, EASE_PRODUCT:
            begin
                e2_opa = e1_tt_reg;
                e2_opb = Q_THREE - (e1_t_reg <<< 1);
            end
            EASE_SQ_QUINTIC:
            begin
                e2_opa = e1_tt_reg;
                e2_opb = e1_tt_reg;
            end
            EASE_QUART_SMOOTH:
            begin
                e2_opa = e1_uu_reg;
                e2_opb = e1_uu_reg;
            end
            default:
            begin
                e2_opa = e1_tt_reg;
                e2_opb = e1_t_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        e2_t_reg     <= e1_t_reg;
        e2_tt_reg    <= e1_tt_reg;
        e2_uu_reg    <= e1_uu_reg;
        e2_sin_reg   <= e1_sin_reg;
        e2_inner_reg <= e1_inner_reg;
        e2_a_reg     <= q_t'({7'b0, e2_third[35:19]});
        e2_r2a_reg   <= qmul(e2_opa, e2_opb);
        e2_r2b_reg   <= qmul(e1_tt_reg, Q_SIX_INT * e1_tt_reg - Q_FIFTEEN) + Q_TEN;
    end

    // ---------------------------------------------------------------
    // E3: third product level; finish every curve that needs no more.
    // ---------------------------------------------------------------
    q_t e3_w;
    q_t e3_opa;
    q_t e3_opb;
    q_t e3_p;
    q_t e3_cr;
    q_t e3_next;
    q_t e3_r_reg, e3_inner_reg, e3_w_reg;

    always_comb
    begin
        e3_w  = Q_ONE - e2_r2a_reg;
        e3_cr = (Q_NINE_INT * e2_tt_reg - e2_t_reg - Q_SIX_INT * e2_r2a_reg + q_t'(1)) >>> 1;
        case (ease_mode_reg) inside
            EASE_COS:
            begin
                e3_opa = e2_t_reg;
                e3_opb = Q_ONE - e2_a_reg;
            end
            EASE_QUINTIC:
            begin
                e3_opa = e2_r2a_reg;
                e3_opb = e2_inner_reg;
            end
            EASE_SQ_QUINTIC:
            begin
                e3_opa = e2_r2a_reg;
                e3_opb = e2_tt_reg;
            end
            EASE_PRODUCT:
            begin
                e3_opa = e2_r2a_reg;
                e3_opb = Q_THREE - (e2_t_reg <<< 1);
            end
            EASE_QUART_SMOOTH:
            begin
                e3_opa = e3_w;
                e3_opb = e3_w;
            end
            default:
            begin
                e3_opa = e2_t_reg;
                e3_opb = e2_t_reg;
            end
        endcase
        e3_p = qmul(e3_opa, e3_opb);
        case (ease_mode_reg) inside
            EASE_COS:                                 e3_next = e3_p + e2_a_reg;
            EASE_QUINTIC, EASE_SQ_QUINTIC,
            EASE_PRODUCT, EASE_QUART_SMOOTH:          e3_next = e3_p;
            EASE_SQUARE:                              e3_next = e2_tt_reg;
            EASE_SINE:                                e3_next = e2_sin_reg;
            EASE_SMOOTH:                              e3_next = e2_r2a_reg;
            EASE_CATMULL:                             e3_next = e3_cr;
            EASE_QUAD_OUT:                            e3_next = Q_ONE - e2_uu_reg;
            EASE_CONST:                               e3_next = Q_ONE;
            default:                                  e3_next = e2_t_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        e3_r_reg     <= e3_next;
        e3_inner_reg <= e2_r2b_reg;
        e3_w_reg     <= e3_w;
    end

    // ---------------------------------------------------------------
    // E4: last product for the chained curves, then clamp to Q2.16.
    // ---------------------------------------------------------------
    q_t    e4_opb;
    q_t    e4_p;
    q_t    e4_next;
    ease_t e4_e_reg;

    always_comb
    begin
        if (ease_mode_reg == EASE_QUART_SMOOTH)
            e4_opb = Q_THREE - (e3_w_reg <<< 1);
        else
            e4_opb = e3_inner_reg;
        e4_p = qmul(e3_r_reg, e4_opb);
        case (ease_mode_reg) inside
            EASE_SQ_QUINTIC, EASE_QUART_SMOOTH: e4_next = e4_p;
            default:                            e4_next = e3_r_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        e4_e_reg <= sat_ease(e4_next);
    end

    // ---------------------------------------------------------------
    // L1: scale each delta by the eased fraction.
    // L2: round, add the start position, saturate, drop out-of-segment.
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] l1_px_reg, l1_py_reg, l1_pz_reg;
    eki_res_t                 result_reg;
    eki_res_t                 result_next;

    always_ff @(posedge clk)
    begin
        l1_px_reg <= carry_reg[CARRY_N-2].diff_x * e4_e_reg;
        l1_py_reg <= carry_reg[CARRY_N-2].diff_y * e4_e_reg;
        l1_pz_reg <= carry_reg[CARRY_N-2].diff_z * e4_e_reg;
    end

    always_comb
    begin
        if (carry_reg[CARRY_N-1].inseg)
        begin
            result_next.in_segment = 1'b1;
            result_next.pos_x      = lerp_fin(carry_reg[CARRY_N-1].start_x, l1_px_reg);
            result_next.pos_y      = lerp_fin(carry_reg[CARRY_N-1].start_y, l1_py_reg);
            result_next.pos_z      = lerp_fin(carry_reg[CARRY_N-1].start_z, l1_pz_reg);
        end
        else
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request taken without a result after the pipeline latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching request");

    a_early_time: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.anim_time < request.seg_start_time))
        |-> ##LATENCY (done && !result.in_segment))
        else $error("time before segment reported as inside");

    a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.seg_start_time == request.seg_end_time) &&
         (request.anim_time == request.seg_start_time))
        |-> ##LATENCY (done && result.in_segment))
        else $error("zero-length segment hit reported as outside");

endmodule
